// File: src/srde_pkg.sv
package srde_pkg;

  localparam int SpikeDepthDefault = 1024;
  localparam int TimeBitsDefault = 32;
  localparam int RateW = 17;
  localparam int GainW = 16;
  localparam logic [RateW-1:0] OneQ16 = 17'h10000;
  localparam logic [GainW-1:0] GainReset = 16'd655;
  localparam logic [1:0] AddrGain = 2'd0;

  typedef enum logic [1:0] {
    KIND_STORE   = 2'd0,
    KIND_ADVANCE = 2'd1,
    KIND_EVAL    = 2'd2,
    KIND_REWIND  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CHECK,
    ST_POW_INIT,
    ST_POW_ACC,
    ST_POW_SQR,
    ST_APPLY,
    ST_FINAL,
    ST_OUT
  } state_t;

  // q1.16 product, rounded half up, clamped to 1.0
  function automatic logic [RateW-1:0] qmul(input logic [RateW-1:0] a,
                                            input logic [RateW-1:0] b);
    logic [2*RateW:0] p;
    logic [2*RateW:0] r;
    begin
      p = (2*RateW+1)'(a) * (2*RateW+1)'(b) + (2*RateW+1)'(32768);
      r = p >> 16;
      qmul = (r > (2*RateW+1)'(OneQ16)) ? OneQ16 : r[RateW-1:0];
    end
  endfunction

endpackage

// File: src/spike_rate_decay_estimator.sv
// channel | dir | tdata bits (low first)                          | tuser
// s_axis  | in  | kind[1:0], time_req, prev_time (TIME_BITS each)  | -
// m_axis  | out | rate[16:0], store_full                           | -
// apb     | cfg | gain at address 0                                | -
// kind 0 and 3 go from the accept straight to the result. kind 1 and 2 walk the store
// from the cursor: a skipped spike is read and passed over; a decayed spike is read, its
// decay is found by square-and-multiply over at most TIME_BITS bits of dt and applied;
// then come the final decay and the result. A spike past the end stops the walk.
// all these steps share the single q1.16 multiplier and the store's one read port.
// rst clears count, cursor and rate and reloads gain; the store itself is not cleared.
// one item at a time; s_tready drops while an item is at work or its result waits.
module spike_rate_decay_estimator #(
  parameter int SPIKE_DEPTH = srde_pkg::SpikeDepthDefault,
  parameter int TIME_BITS = srde_pkg::TimeBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((2+2*TIME_BITS+7)/8)*8-1:0] s_tdata, // kind, time_req, prev_time
  output logic m_tvalid,
  input  logic m_tready,
  output logic [23:0] m_tdata, // rate, store_full
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import srde_pkg::*;

  localparam int IdxW = $clog2(SPIKE_DEPTH);
  localparam int CntW = $clog2(SPIKE_DEPTH + 1);
  localparam int BitW = $clog2(TIME_BITS + 1);

  logic [TIME_BITS-1:0] mem [SPIKE_DEPTH];
  logic [TIME_BITS-1:0] rd_data;
  logic [IdxW-1:0] rd_addr;
  logic mem_we;
  logic [IdxW-1:0] wr_addr;

  state_t state, state_next;
  logic [GainW-1:0] gain;
  logic [CntW-1:0] count, cursor, cursor_next;
  logic [RateW-1:0] rate_value, rate_value_next;
  logic [RateW-1:0] rate, rate_next, base, base_next, acc, acc_next;
  logic [TIME_BITS-1:0] t_end, t_end_next, start, start_next, dt, dt_next;
  logic [TIME_BITS-1:0] spike, spike_next;
  logic [BitW-1:0] nbit, nbit_next;
  logic is_final, is_final_next, is_eval, is_eval_next;
  logic full, full_next;
  logic [RateW-1:0] out_rate, out_rate_next;
  logic [RateW-1:0] mul_a, mul_b, mul_q;

  logic [1:0] in_kind;
  logic [TIME_BITS-1:0] in_time, in_prev;
  logic [RateW-1:0] rate_add;
  logic cfg_wr;

  assign in_kind = s_tdata[1:0];
  assign in_time = s_tdata[2 +: TIME_BITS];
  assign in_prev = s_tdata[2+TIME_BITS +: TIME_BITS];
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == AddrGain) ? {16'd0, gain} : 32'd0;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata = {6'd0, full, out_rate};

  assign mul_q = qmul(mul_a, mul_b);
  assign rate_add = mul_q + RateW'(gain);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= in_time;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      gain <= GainReset;
      count <= '0;
      cursor <= '0;
      rate_value <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr && paddr == AddrGain) gain <= pwdata[GainW-1:0];
      if (mem_we) count <= count + CntW'(1);
      cursor <= cursor_next;
      rate_value <= rate_value_next;
    end
  end

  always_ff @(posedge clk) begin
    rate <= rate_next;
    base <= base_next;
    acc <= acc_next;
    t_end <= t_end_next;
    start <= start_next;
    dt <= dt_next;
    spike <= spike_next;
    nbit <= nbit_next;
    is_final <= is_final_next;
    is_eval <= is_eval_next;
    full <= full_next;
    out_rate <= out_rate_next;
  end

  always_comb begin
    state_next = state;
    cursor_next = cursor;
    rate_value_next = rate_value;
    rate_next = rate;
    base_next = base;
    acc_next = acc;
    t_end_next = t_end;
    start_next = start;
    dt_next = dt;
    spike_next = spike;
    nbit_next = nbit;
    is_final_next = is_final;
    is_eval_next = is_eval;
    full_next = full;
    out_rate_next = out_rate;
    mem_we = 1'b0;
    wr_addr = count[IdxW-1:0];
    rd_addr = cursor[IdxW-1:0];
    mul_a = acc;
    mul_b = base;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          full_next = 1'b0;
          t_end_next = in_time;
          case (in_kind)
            KIND_STORE: begin
              if (count < CntW'(SPIKE_DEPTH)) mem_we = 1'b1;
              else full_next = 1'b1;
              out_rate_next = rate_value;
              state_next = ST_OUT;
            end
            KIND_ADVANCE: begin
              is_eval_next = 1'b0;
              if (in_time < in_prev) begin
                rate_next = '0;
                start_next = '0;
                cursor_next = '0;
              end else begin
                rate_next = rate_value;
                start_next = in_prev;
              end
              state_next = ST_RD;
            end
            KIND_EVAL: begin
              is_eval_next = 1'b1;
              rate_next = '0;
              start_next = '0;
              cursor_next = '0;
              state_next = ST_RD;
            end
            default: begin
              cursor_next = '0;
              out_rate_next = rate_value;
              state_next = ST_OUT;
            end
          endcase
        end
      end
      ST_RD: begin
        // read issued at cursor; data arrives next cycle
        if (cursor < count) state_next = ST_CHECK;
        else state_next = ST_FINAL;
      end
      ST_CHECK: begin
        spike_next = rd_data;
        if (rd_data > start) begin
          if (rd_data <= t_end) begin
            dt_next = rd_data - start;
            is_final_next = 1'b0;
            state_next = ST_POW_INIT;
          end else begin
            state_next = ST_FINAL;
          end
        end else begin
          cursor_next = cursor + CntW'(1);
          state_next = ST_RD;
        end
      end
      ST_FINAL: begin
        if (t_end > start) begin
          dt_next = t_end - start;
          is_final_next = 1'b1;
          state_next = ST_POW_INIT;
        end else begin
          state_next = ST_APPLY;
          is_final_next = 1'b1;
          acc_next = OneQ16;
        end
      end
      ST_POW_INIT: begin
        acc_next = OneQ16;
        base_next = OneQ16 - RateW'(gain);
        nbit_next = '0;
        state_next = ST_POW_ACC;
      end
      ST_POW_ACC: begin
        if (dt == '0 || nbit == BitW'(TIME_BITS)) begin
          state_next = ST_APPLY;
        end else begin
          if (dt[0]) acc_next = mul_q;
          state_next = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        mul_a = base;
        mul_b = base;
        base_next = mul_q;
        dt_next = dt >> 1;
        nbit_next = nbit + BitW'(1);
        state_next = ST_POW_ACC;
      end
      ST_APPLY: begin
        mul_a = rate;
        mul_b = acc;
        if (is_final) begin
          out_rate_next = mul_q;
          if (!is_eval) rate_value_next = mul_q;
          state_next = ST_OUT;
        end else begin
          rate_next = (rate_add > OneQ16) ? OneQ16 : rate_add;
          start_next = spike;
          cursor_next = cursor + CntW'(1);
          state_next = ST_RD;
        end
      end
      ST_OUT: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_rate <= OneQ16) else $error("rate above 1.0");
  a_cursor_le_count: assert property (@(posedge clk) disable iff (rst)
    cursor <= count) else $error("cursor past count");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(SPIKE_DEPTH)) else $error("count over depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("accept while busy");
`endif

endmodule
